/* src/radix_string_converter_unit_defines.svh */
// ============================================================================
// Radix String Converter - assertion macros
// Shared concurrent assertion helpers, compiled out when SYNTH is defined.
// ============================================================================
`ifndef RADIX_STRING_CONVERTER_UNIT_DEFINES_SVH
`define RADIX_STRING_CONVERTER_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, disabled while reset is asserted
`define RSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rsc: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rsc: assertion failed");

`else

`define RSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/rsc_pkg.sv */
// ============================================================================
// Radix String Converter - package
// Shared types, constants and digit/character helpers.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

    localparam int CHAR_W      = 8;
    localparam int BASE_W      = 6;
    localparam int DVAL_W      = 7;   // digit value incl. the "not a digit" code
    localparam int DIGIT_DEPTH = 32;
    localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);
    localparam int CNT_W       = DIGIT_AW + 1;
    localparam int DIV_STEP    = 8;   // quotient bits per divider cycle

    localparam logic [BASE_W-1:0] BASE_MIN      = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX      = 6'd36;
    localparam logic [BASE_W-1:0] SRC_BASE_RST  = 6'd10;
    localparam logic [BASE_W-1:0] TGT_BASE_RST  = 6'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;  // 'Z'
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;  // 'z'
    localparam logic [CHAR_W-1:0] DEC_RADIX  = 8'd10;
    localparam logic [DVAL_W-1:0] DVAL_NONE  = 7'd64;

    // configuration register indexes
    localparam logic CFG_SOURCE_BASE = 1'b0;
    localparam logic CFG_TARGET_BASE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_DIGIT    = 2'd1,
        STAT_OVERFLOW = 2'd2
    } t_status;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end else begin
            r = b;
        end
        return r;
    endfunction

    function automatic logic [DVAL_W-1:0] ascii_value(input logic [CHAR_W-1:0] c);
        logic [DVAL_W-1:0] v;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = DVAL_W'(c - CHAR_ZERO);
        end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
            v = DVAL_W'(c - CHAR_UA + DEC_RADIX);
        end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
            v = DVAL_W'(c - CHAR_LA + DEC_RADIX);
        end else begin
            v = DVAL_NONE;
        end
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] value_to_ascii(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (CHAR_W'(d) < DEC_RADIX) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_UA + CHAR_W'(d) - DEC_RADIX;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/rsc_in_if.sv */
// ============================================================================
// Radix String Converter - input channel
// Valid/ready channel carrying one source character per transaction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface rsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

`default_nettype wire

/* src/rsc_out_if.sv */
// ============================================================================
// Radix String Converter - output channel
// Valid/ready channel carrying one target digit or error per transaction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface rsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;
    logic [1:0] status;

    modport source (output valid, output out_char, output out_last, output status,
                    input ready);
    modport sink   (input valid, input out_char, input out_last, input status,
                    output ready);
endinterface

`default_nettype wire

/* src/radix_string_converter_unit.sv */
// ============================================================================
// Radix String Converter Unit - top level
// Converts ASCII digit strings from one configurable radix to another.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

// Feed the digits of one number, most significant first, one character per
// input transaction, with in_last set on the final character. Digits are
// 0-9, A-Z or a-z and must be below source_base. Characters are taken one
// per cycle while the job queue is not full and folded into a VALUE_BITS-bit
// accumulator. On the last one the number is queued for conversion and the
// block goes on taking the next number's characters; a two-entry job queue
// lets this front end run ahead of the back end. The back end divides by
// target_base with a shared iterative divider that resolves eight quotient
// bits per cycle, producing one target digit per pass over the value, and
// then replays the digit buffer through its read, load and send states per
// output transaction, waiting while the sink holds ready low. Output is
// uppercase ASCII, last digit marked. A zero value gives a single '0'. An
// invalid digit or an accumulator overflow gives one transaction with
// out_char 0, out_last 1 and status 1 or 2; characters after the first error
// are ignored up to the last mark. Register 0 is source_base and register 1
// is target_base (reset 10 and 2); values below 2 act as 2 and above 36 act
// as 36. Write them only while no number is in flight.

module radix_string_converter_unit
    import rsc_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    rsc_in_if.sink                 i_in,
    rsc_out_if.source              o_out,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [BASE_W-1:0] i_cfg_data
);

    localparam int JOB_W = VALUE_BITS + 2;

    // config registers, stored raw and clamped on use
    logic [BASE_W-1:0] r_src_base;
    logic [BASE_W-1:0] r_tgt_base;
    logic [BASE_W-1:0] w_src_base;
    logic [BASE_W-1:0] w_tgt_base;

    // front end -> queue -> back end
    logic              w_push;
    logic [JOB_W-1:0]  w_push_job;
    logic              w_full;
    logic              w_job_valid;
    logic [JOB_W-1:0]  w_job;
    logic              w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base <= SRC_BASE_RST;
            r_tgt_base <= TGT_BASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SOURCE_BASE: r_src_base <= i_cfg_data;
                CFG_TARGET_BASE: r_tgt_base <= i_cfg_data;
                default: begin
                    r_src_base <= r_src_base;
                end
            endcase
        end
    end

    assign w_src_base = clamp_base(r_src_base);
    assign w_tgt_base = clamp_base(r_tgt_base);

    // character classification and accumulation
    rsc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_src_base (w_src_base),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // one job per number: {status, value}
    rsc_fifo #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .o_data  (w_job),
        .i_pop   (w_pop)
    );

    // radix conversion and digit emission
    rsc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tgt_base  (w_tgt_base),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* src/rsc_ram.sv */
// ============================================================================
// Radix String Converter - generic RAM
// One write port, one read port, registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rsc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/rsc_fifo.sv */
// ============================================================================
// Radix String Converter - job queue
// Two-entry queue between the character front end and the digit back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rsc_fifo #(
    parameter int WIDTH = 34
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data,
    input  wire logic             i_pop
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

`default_nettype wire

/* src/rsc_front.sv */
// ============================================================================
// Radix String Converter - front end
// Classifies source characters and accumulates the value; queues one job
// per number.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "radix_string_converter_unit_defines.svh"

module rsc_front
    import rsc_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    rsc_in_if.sink                       i_in,
    input  wire logic [BASE_W-1:0]       i_src_base,
    input  wire logic                    i_full,
    output logic                         o_push,
    output logic      [VALUE_BITS+1:0]   o_job
);

    localparam int PW = VALUE_BITS + BASE_W + 1;

    logic [VALUE_BITS-1:0] r_acc;
    t_status               r_err;
    logic [VALUE_BITS-1:0] n_acc;
    t_status               n_err;

    logic                  w_accept;
    logic [DVAL_W-1:0]     w_dval;
    logic [PW-1:0]         w_prod;
    logic                  w_ovf;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    assign w_dval = ascii_value(i_in.in_char);
    // acc * base + digit; any bit above the value width means overflow
    assign w_prod = PW'(r_acc) * PW'(i_src_base) + PW'(w_dval);
    assign w_ovf  = |w_prod[PW-1:VALUE_BITS];

    always_comb begin
        n_acc = r_acc;
        n_err = r_err;
        if (r_err == STAT_OK) begin
            if (w_dval >= DVAL_W'(i_src_base)) begin
                n_err = STAT_DIGIT;
            end else if (w_ovf) begin
                n_err = STAT_OVERFLOW;
            end else begin
                n_acc = w_prod[VALUE_BITS-1:0];
            end
        end
    end

    assign o_push = w_accept && i_in.in_last;
    assign o_job  = {n_err, n_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_err <= STAT_OK;
        end else if (w_accept) begin
            if (i_in.in_last) begin
                r_acc <= '0;
                r_err <= STAT_OK;
            end else begin
                r_acc <= n_acc;
                r_err <= n_err;
            end
        end
    end

    `RSC_ASSERT_IMPLY(a_push_not_full, i_clk, i_rst_n, o_push, !i_full)
    `RSC_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, w_accept && i_in.in_last,
                     r_acc == '0 && r_err == STAT_OK)
    `RSC_ASSERT_NEXT(a_error_sticks, i_clk, i_rst_n,
                     w_accept && !i_in.in_last && r_err != STAT_OK,
                     r_err == $past(r_err) && r_acc == $past(r_acc))

endmodule

`default_nettype wire

/* src/rsc_back.sv */
// ============================================================================
// Radix String Converter - back end
// Iterative division by the target base, digit buffer, digit emission.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "radix_string_converter_unit_defines.svh"

module rsc_back
    import rsc_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [BASE_W-1:0]       i_tgt_base,
    input  wire logic                    i_job_valid,
    input  wire logic [VALUE_BITS+1:0]   i_job,
    output logic                         o_pop,
    rsc_out_if.source                    o_out
);

    localparam int DIV_CYC = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W   = DIV_CYC * DIV_STEP;
    localparam int DC_W    = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_LOAD,
        S_SEND
    } t_state;

    t_state                r_state;
    logic [DIV_W-1:0]      r_num;     // dividend shifting out, quotient shifting in
    logic [BASE_W-1:0]     r_rem;
    logic [DC_W-1:0]       r_dcyc;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIGIT_AW-1:0]   r_idx;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_last;
    t_status               r_out_status;

    logic [DIV_W-1:0]      n_num;
    logic [BASE_W-1:0]     n_rem;
    logic [BASE_W:0]       w_trial;
    logic                  w_last_cyc;
    logic [CNT_W-1:0]      w_cnt_inc;
    logic [BASE_W-1:0]     w_rdata;
    t_status               w_job_err;

    // eight restoring division steps on the narrow remainder
    always_comb begin
        n_num   = r_num;
        n_rem   = r_rem;
        w_trial = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            w_trial = {n_rem, n_num[DIV_W-1]};
            n_num   = {n_num[DIV_W-2:0], 1'b0};
            if (w_trial >= {1'b0, i_tgt_base}) begin
                n_rem    = BASE_W'(w_trial - {1'b0, i_tgt_base});
                n_num[0] = 1'b1;
            end else begin
                n_rem = w_trial[BASE_W-1:0];
            end
        end
    end

    assign w_last_cyc = (r_state == S_DIV) && (r_dcyc == '0);
    assign w_cnt_inc  = r_cnt + 1'b1;
    assign w_job_err  = t_status'(i_job[VALUE_BITS+1:VALUE_BITS]);
    assign o_pop      = (r_state == S_IDLE) && i_job_valid;

    rsc_ram #(
        .WIDTH (BASE_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (w_last_cyc),
        .i_waddr (r_cnt[DIGIT_AW-1:0]),
        .i_wdata (n_rem),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        if (w_job_err != STAT_OK) begin
                            r_out_char   <= '0;
                            r_out_last   <= 1'b1;
                            r_out_status <= w_job_err;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_SEND;
                        end else begin
                            r_num   <= DIV_W'(i_job[VALUE_BITS-1:0]);
                            r_rem   <= '0;
                            r_dcyc  <= DC_W'(DIV_CYC - 1);
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_num <= n_num;
                    if (r_dcyc == '0) begin
                        r_cnt <= w_cnt_inc;
                        if (n_num == '0) begin
                            r_idx   <= r_cnt[DIGIT_AW-1:0];
                            r_state <= S_READ;
                        end else if (w_cnt_inc == CNT_W'(DIGIT_DEPTH)) begin
                            // more digits than the buffer holds
                            r_out_char   <= '0;
                            r_out_last   <= 1'b1;
                            r_out_status <= STAT_OVERFLOW;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_SEND;
                        end else begin
                            // next digit starts from a clear remainder
                            r_rem  <= '0;
                            r_dcyc <= DC_W'(DIV_CYC - 1);
                        end
                    end else begin
                        r_rem  <= n_rem;
                        r_dcyc <= r_dcyc - 1'b1;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_out_char   <= value_to_ascii(w_rdata);
                    r_out_last   <= (r_idx == '0);
                    r_out_status <= STAT_OK;
                    r_out_valid  <= 1'b1;
                    r_state      <= S_SEND;
                end
                S_SEND: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.out_last = r_out_last;
    assign o_out.status   = r_out_status;

    `RSC_ASSERT_IMPLY(a_error_shape, i_clk, i_rst_n,
                      r_out_valid && r_out_status != STAT_OK,
                      r_out_char == '0 && r_out_last)
    `RSC_ASSERT_IMPLY(a_digit_room, i_clk, i_rst_n, r_state == S_DIV,
                      r_cnt < CNT_W'(DIGIT_DEPTH))
    `RSC_ASSERT_IMPLY(a_valid_in_send, i_clk, i_rst_n, 1'b1,
                      (r_state == S_SEND) == r_out_valid)

endmodule

`default_nettype wire
